// ===== hw/rtl/lrtf_pkg.sv =====
// Shared constants and types for the longest-remaining-time-first scheduler.
// No dependencies; used by lrtf_rank_cmp and lrtf_preemptive_scheduler_core.
`default_nettype none

package lrtf_pkg;

  // table geometry
  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // fixed field widths
  localparam int SLOT_W = 4;
  localparam int DUR_W  = 16;
  localparam int TIME_W = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // command codes
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // ranking key of one slot
  typedef struct packed {
    logic [DUR_W-1:0] remaining;
    logic [DUR_W-1:0] arrival;
  } rank_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lrtf_preemptive_scheduler_core.sv =====
// Longest-remaining-time-first preemptive scheduler over a table of task slots.
// A load beat (command 0) is taken while idle and gives no result. A tick beat
// (command 1) sweeps the slot table through one read port and one shared ranking
// comparator, one slot per cycle behind the registered read, then updates the
// winner and works out its completion, turnaround and waiting times in the COMP,
// TURN and REPORT states: done pulses when REPORT ends, and busy drops in that
// same cycle, so a new tick is taken only once the last one is through.
// Each result is on the outputs for the single cycle in which done is high; the
// receiver cannot hold it off and must capture it then.
// Depends on lrtf_pkg and lrtf_rank_cmp.
`default_nettype none

module lrtf_preemptive_scheduler_core (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire                          command,
  input  wire [lrtf_pkg::SLOT_W-1:0]   slot,
  input  wire [lrtf_pkg::DUR_W-1:0]    arrival_time,
  input  wire [lrtf_pkg::DUR_W-1:0]    burst_length,
  output logic                         done,
  output logic [lrtf_pkg::TIME_W-1:0]  tick_time,
  output logic                         idle,
  output logic [lrtf_pkg::SLOT_W-1:0]  ran_slot,
  output logic                         finished,
  output logic [lrtf_pkg::TIME_W-1:0]  completion_time,
  output logic [lrtf_pkg::TIME_W-1:0]  turnaround_time,
  output logic [lrtf_pkg::TIME_W-1:0]  waiting_time,
  output logic                         all_done
);

  localparam int MEM_W = 3 * lrtf_pkg::DUR_W;
  localparam logic [lrtf_pkg::IDX_W-1:0] LAST_IDX = lrtf_pkg::IDX_W'(lrtf_pkg::NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMP,
    ST_TURN,
    ST_REPORT
  } state_t;

  state_t state;

  // per-slot flags and time
  logic [lrtf_pkg::NUM_SLOTS-1:0] loaded;
  logic [lrtf_pkg::NUM_SLOTS-1:0] complete;
  logic [lrtf_pkg::TIME_W-1:0]    cur_time;

  // sweep control
  logic [lrtf_pkg::IDX_W-1:0] rd_addr;
  logic                       issued_all;
  logic                       pipe_vld;
  logic [lrtf_pkg::IDX_W-1:0] pipe_idx;

  // best candidate so far
  logic                       found;
  logic [lrtf_pkg::IDX_W-1:0] best_idx;
  logic [lrtf_pkg::DUR_W-1:0] best_rem;
  logic [lrtf_pkg::DUR_W-1:0] best_arr;
  logic [lrtf_pkg::DUR_W-1:0] best_burst;

  // finishing arithmetic
  logic                        fin;
  logic [lrtf_pkg::TIME_W-1:0] comp;
  logic [lrtf_pkg::TIME_W-1:0] turn;

  // task table: {arrival, burst, remaining}
  logic [MEM_W-1:0]           task_mem [lrtf_pkg::NUM_SLOTS];
  logic [MEM_W-1:0]           rdata;
  logic                       mem_we;
  logic [lrtf_pkg::IDX_W-1:0] mem_wa;
  logic [MEM_W-1:0]           mem_wd;

  logic                       load_ok;
  logic                       accept;
  logic [lrtf_pkg::DUR_W-1:0] rd_arr;
  logic [lrtf_pkg::DUR_W-1:0] rd_burst;
  logic [lrtf_pkg::DUR_W-1:0] rd_rem;
  logic                       eligible;
  logic                       wins;
  lrtf_pkg::rank_t            cand_key;
  lrtf_pkg::rank_t            best_key;
  logic [lrtf_pkg::TIME_W-1:0] wait_val;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign load_ok = (int'(slot) < lrtf_pkg::NUM_SLOTS);

  assign rd_arr   = rdata[MEM_W-1 -: lrtf_pkg::DUR_W];
  assign rd_burst = rdata[2*lrtf_pkg::DUR_W-1 -: lrtf_pkg::DUR_W];
  assign rd_rem   = rdata[lrtf_pkg::DUR_W-1:0];

  // slot under compare is live and has arrived
  assign eligible = loaded[pipe_idx] && !complete[pipe_idx] &&
                    ({{(lrtf_pkg::TIME_W-lrtf_pkg::DUR_W){1'b0}}, rd_arr} <= cur_time);

  assign cand_key.remaining = rd_rem;
  assign cand_key.arrival   = rd_arr;
  assign best_key.remaining = best_rem;
  assign best_key.arrival   = best_arr;

  lrtf_rank_cmp u_cmp (
    .cand       (cand_key),
    .best       (best_key),
    .best_valid (found),
    .wins       (wins)
  );

  // waiting time, floored at zero
  assign wait_val = (turn >= {{(lrtf_pkg::TIME_W-lrtf_pkg::DUR_W){1'b0}}, best_burst}) ?
                    (turn - {{(lrtf_pkg::TIME_W-lrtf_pkg::DUR_W){1'b0}}, best_burst}) :
                    '0;

  // table write port: loads from idle, service write-back after the sweep
  always_comb begin
    mem_we = 1'b0;
    mem_wa = best_idx;
    mem_wd = {best_arr, best_burst, best_rem - 1'b1};
    if (state == ST_IDLE) begin
      mem_we = accept && (command == lrtf_pkg::CMD_LOAD) && load_ok;
      mem_wa = lrtf_pkg::IDX_W'(slot);
      mem_wd = {arrival_time, burst_length, burst_length};
    end else if (state == ST_COMP) begin
      mem_we = found;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      task_mem[mem_wa] <= mem_wd;
    end
    rdata <= task_mem[rd_addr];
  end

  // sequencer, flags and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      done     <= 1'b0;
      loaded   <= '0;
      complete <= '0;
      cur_time <= '0;
      pipe_vld <= 1'b0;
      found    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (command == lrtf_pkg::CMD_LOAD) begin
              if (load_ok) begin
                loaded[lrtf_pkg::IDX_W'(slot)]   <= 1'b1;
                complete[lrtf_pkg::IDX_W'(slot)] <= (burst_length == '0);
              end
            end else begin
              rd_addr    <= '0;
              issued_all <= 1'b0;
              pipe_vld   <= 1'b0;
              found      <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pipe_vld <= !issued_all;
          pipe_idx <= rd_addr;
          if (!issued_all) begin
            if (rd_addr == LAST_IDX) begin
              issued_all <= 1'b1;
            end else begin
              rd_addr <= rd_addr + 1'b1;
            end
          end
          if (pipe_vld && eligible && wins) begin
            found      <= 1'b1;
            best_idx   <= pipe_idx;
            best_rem   <= rd_rem;
            best_arr   <= rd_arr;
            best_burst <= rd_burst;
          end
          if (pipe_vld && (pipe_idx == LAST_IDX)) begin
            state <= ST_COMP;
          end
        end
        ST_COMP: begin
          fin  <= found && (best_rem == lrtf_pkg::DUR_W'(1));
          comp <= (cur_time == lrtf_pkg::TIME_MAX) ? lrtf_pkg::TIME_MAX : cur_time + 1'b1;
          if (found && (best_rem == lrtf_pkg::DUR_W'(1))) begin
            complete[best_idx] <= 1'b1;
          end
          state <= ST_TURN;
        end
        ST_TURN: begin
          turn  <= comp - {{(lrtf_pkg::TIME_W-lrtf_pkg::DUR_W){1'b0}}, best_arr};
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          tick_time       <= cur_time;
          idle            <= !found;
          ran_slot        <= found ? lrtf_pkg::SLOT_W'(best_idx) : '0;
          finished        <= fin;
          completion_time <= fin ? comp : '0;
          turnaround_time <= fin ? turn : '0;
          waiting_time    <= fin ? wait_val : '0;
          all_done        <= &(~loaded | complete);
          done            <= 1'b1;
          if (cur_time != lrtf_pkg::TIME_MAX) begin
            cur_time <= cur_time + 1'b1;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result beat only ever follows the report step
  a_done_after_report: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_REPORT))
    else $error("result beat without a report step");

  // an idle tick names no slot and finishes nothing
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (done && idle) |-> ((ran_slot == '0) && !finished))
    else $error("idle tick carries slot or finish");

  // waiting time never exceeds turnaround
  a_wait_le_turn: assert property (@(posedge clk) disable iff (rst)
    (done && finished) |-> (waiting_time <= turnaround_time))
    else $error("waiting time above turnaround");

  // time counter never runs backwards
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (cur_time >= $past(cur_time)))
    else $error("time counter went backwards");

  // an accepted tick holds the block busy
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == lrtf_pkg::CMD_TICK)) |=> busy)
    else $error("tick accepted but block not busy");

endmodule

`default_nettype wire

// ===== hw/rtl/lrtf_rank_cmp.sv =====
// Shared ranking comparator: decides whether a candidate slot displaces the
// current best. Depends on lrtf_pkg (rank_t).
`default_nettype none

module lrtf_rank_cmp (
  input  wire lrtf_pkg::rank_t cand,
  input  wire lrtf_pkg::rank_t best,
  input  wire                  best_valid,
  output logic                 wins
);

  // longer remaining wins, then earlier arrival; a full tie keeps the lower slot
  always_comb begin
    if (!best_valid) begin
      wins = 1'b1;
    end else if (cand.remaining != best.remaining) begin
      wins = (cand.remaining > best.remaining);
    end else begin
      wins = (cand.arrival < best.arrival);
    end
  end

endmodule

`default_nettype wire
